### design/lru_sector_cache_tags_assert.svh
// Assertion macros shared by the sector cache tag controller.
`ifndef LRU_SECTOR_CACHE_TAGS_ASSERT_SVH
`define LRU_SECTOR_CACHE_TAGS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LSCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lsct_pkg.sv
// ----------------------------------------------------------------------------
// lsct_pkg
// Types and codes shared by the sector cache tag controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lsct_pkg;

    localparam int unsigned SectorW = 32;
    localparam int unsigned SlotOutW = 6;

    // Operation codes of an input word
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Result kinds
    typedef enum logic [1:0] {
        K_ACCESS = 2'd0,
        K_PREF   = 2'd1,
        K_FLWB   = 2'd2,
        K_FLDONE = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]         operation;
        logic [SectorW-1:0] sector;
        logic [SectorW-1:0] pf_sector;
        logic               next_valid;
    } t_in;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SlotOutW-1:0] slot;
        logic                hit;
        logic                fill_needed;
        logic                writeback_needed;
        logic [SectorW-1:0]  writeback_sector;
        logic                last;
    } t_out;

    // Datapath commands
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_LOAD_NEXT,
        DP_RD_ORD,
        DP_RD_SEC,
        DP_CMP,
        DP_INSTALL,
        DP_EVICT,
        DP_SH_RD,
        DP_SH_WR,
        DP_MRU_WR,
        DP_EMIT,
        DP_INC,
        DP_FL_RD,
        DP_FL_EMIT,
        DP_FL_DONE
    } t_dp_op;

    // Datapath status toward the controller
    typedef struct packed {
        logic used_zero;
        logic full;
        logic match;
        logic scan_end;
        logic touch;
        logic more;
        logic dirty_i;
        logic fl_last;
        logic none_dirty;
    } t_dp_stat;

endpackage

`default_nettype wire

### design/lsct_dpath.sv
// ----------------------------------------------------------------------------
// lsct_dpath
// Tag memory, LRU order memory, dirty marks, scan index and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsct_dpath #(
    parameter int unsigned NUM_SLOTS = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lsct_pkg::t_dp_op  i_cmd,
    input  wire lsct_pkg::t_in     i_item,
    output lsct_pkg::t_dp_stat     o_stat,
    output logic                   o_strobe,
    output lsct_pkg::t_out         o_result
);

    localparam int unsigned IW = $clog2(NUM_SLOTS);
    localparam int unsigned UW = $clog2(NUM_SLOTS + 1);
    localparam int unsigned SW = lsct_pkg::SectorW;

    // Memories
    logic [SW-1:0] r_sector [NUM_SLOTS];
    logic [IW-1:0] r_order  [NUM_SLOTS];

    // Control state
    logic [UW-1:0]        r_used;
    logic [NUM_SLOTS-1:0] r_dirty;
    logic                 r_strobe;

    // Working registers
    logic [SW-1:0]   r_key, r_nsec, r_sec_q, r_vic_sec, r_wbs;
    logic [IW-1:0]   r_i, r_ord_q, r_vic_slot, r_res_slot;
    logic            r_nvalid, r_is_wr, r_touch, r_hit, r_wb;
    lsct_pkg::t_kind r_kind;
    lsct_pkg::t_out  r_out;

    logic [IW-1:0]        w_i_p1;
    logic [IW-1:0]        w_used_lo;
    logic [NUM_SLOTS-1:0] w_rest;

    assign w_i_p1    = r_i + IW'(1);
    assign w_used_lo = IW'(r_used);
    assign w_rest    = r_dirty & ~({{(NUM_SLOTS-1){1'b0}}, 1'b1} << r_i);

    // Status
    always_comb begin
        o_stat.used_zero  = (r_used == '0);
        o_stat.full       = (r_used == UW'(NUM_SLOTS));
        o_stat.match      = (r_sec_q == r_key);
        o_stat.scan_end   = ((UW'(r_i) + UW'(1)) == r_used);
        o_stat.touch      = r_touch;
        o_stat.more       = (r_kind == lsct_pkg::K_ACCESS) && r_nvalid;
        o_stat.dirty_i    = r_dirty[r_i];
        o_stat.fl_last    = (w_rest == '0);
        o_stat.none_dirty = (r_dirty == '0);
    end

    // Occupancy, dirty marks and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_dirty  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (i_cmd)
                lsct_pkg::DP_INSTALL: begin
                    r_used             <= r_used + UW'(1);
                    r_dirty[w_used_lo] <= 1'b0;
                end
                lsct_pkg::DP_EVICT:   r_dirty[r_vic_slot] <= 1'b0;
                lsct_pkg::DP_EMIT: begin
                    r_strobe <= 1'b1;
                    if (r_kind == lsct_pkg::K_ACCESS && r_is_wr) begin
                        r_dirty[r_res_slot] <= 1'b1;
                    end
                end
                lsct_pkg::DP_FL_EMIT: begin
                    r_strobe     <= 1'b1;
                    r_dirty[r_i] <= 1'b0;
                end
                lsct_pkg::DP_FL_DONE: r_strobe <= 1'b1;
                default: ;
            endcase
        end
    end

    // Memories and working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            lsct_pkg::DP_LOAD: begin
                r_key    <= i_item.sector;
                r_nsec   <= i_item.pf_sector;
                r_nvalid <= i_item.next_valid;
                r_is_wr  <= (i_item.operation == lsct_pkg::OP_WRITE);
                r_touch  <= 1'b1;
                r_kind   <= lsct_pkg::K_ACCESS;
                r_i      <= '0;
                r_hit    <= 1'b0;
                r_wb     <= 1'b0;
                r_wbs    <= '0;
            end
            lsct_pkg::DP_LOAD_NEXT: begin
                r_key   <= r_nsec;
                r_touch <= 1'b0;
                r_kind  <= lsct_pkg::K_PREF;
                r_i     <= '0;
                r_hit   <= 1'b0;
                r_wb    <= 1'b0;
                r_wbs   <= '0;
            end
            lsct_pkg::DP_RD_ORD: r_ord_q <= r_order[r_i];
            lsct_pkg::DP_RD_SEC: r_sec_q <= r_sector[r_ord_q];
            lsct_pkg::DP_CMP: begin
                // LRU end doubles as the eviction candidate
                if (r_i == '0) begin
                    r_vic_slot <= r_ord_q;
                    r_vic_sec  <= r_sec_q;
                end
                if (r_sec_q == r_key) begin
                    r_hit      <= 1'b1;
                    r_res_slot <= r_ord_q;
                end else begin
                    r_i <= w_i_p1;
                end
            end
            lsct_pkg::DP_INSTALL: begin
                r_order[w_used_lo]  <= w_used_lo;
                r_sector[w_used_lo] <= r_key;
                r_res_slot          <= w_used_lo;
            end
            lsct_pkg::DP_EVICT: begin
                r_sector[r_vic_slot] <= r_key;
                r_res_slot           <= r_vic_slot;
                r_wb                 <= r_dirty[r_vic_slot];
                r_wbs                <= r_dirty[r_vic_slot] ? r_vic_sec : '0;
                r_i                  <= '0;
            end
            lsct_pkg::DP_SH_RD:  r_ord_q <= r_order[w_i_p1];
            lsct_pkg::DP_SH_WR: begin
                r_order[r_i] <= r_ord_q;
                r_i          <= w_i_p1;
            end
            lsct_pkg::DP_MRU_WR: r_order[r_i] <= r_res_slot;
            lsct_pkg::DP_EMIT: begin
                r_out.kind             <= r_kind;
                r_out.slot             <= lsct_pkg::SlotOutW'(r_res_slot);
                r_out.hit              <= r_hit;
                r_out.fill_needed      <= !r_hit;
                r_out.writeback_needed <= r_wb;
                r_out.writeback_sector <= r_wbs;
                r_out.last             <= (r_kind == lsct_pkg::K_PREF) || !r_nvalid;
            end
            lsct_pkg::DP_INC:   r_i     <= w_i_p1;
            lsct_pkg::DP_FL_RD: r_sec_q <= r_sector[r_i];
            lsct_pkg::DP_FL_EMIT: begin
                r_out.kind             <= lsct_pkg::K_FLWB;
                r_out.slot             <= lsct_pkg::SlotOutW'(r_i);
                r_out.hit              <= 1'b0;
                r_out.fill_needed      <= 1'b0;
                r_out.writeback_needed <= 1'b1;
                r_out.writeback_sector <= r_sec_q;
                r_out.last             <= (w_rest == '0);
                r_i                    <= w_i_p1;
            end
            lsct_pkg::DP_FL_DONE: begin
                r_out.kind             <= lsct_pkg::K_FLDONE;
                r_out.slot             <= '0;
                r_out.hit              <= 1'b0;
                r_out.fill_needed      <= 1'b0;
                r_out.writeback_needed <= 1'b0;
                r_out.writeback_sector <= '0;
                r_out.last             <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

`default_nettype wire

### design/lsct_ctrl.sv
// ----------------------------------------------------------------------------
// lsct_ctrl
// Sequencer: lookup scan, install or evict, LRU shift, result, flush walk.
// ----------------------------------------------------------------------------
`default_nettype none

module lsct_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [1:0]         i_op,
    input  wire lsct_pkg::t_dp_stat i_stat,
    output lsct_pkg::t_dp_op        o_cmd,
    output logic                    o_busy
);

    typedef enum logic [3:0] {
        S_IDLE, S_BEGIN, S_ORD, S_SEC, S_CMP, S_INSTALL, S_EVICT,
        S_SH_CHK, S_SH_RD, S_SH_WR, S_MRU, S_EMIT, S_NEXT,
        S_FL_CHK, S_FL_RD, S_FL_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_flush;

    assign w_flush = (i_op == lsct_pkg::OP_FLUSH);

    // Command and next state
    always_comb begin
        o_cmd   = lsct_pkg::DP_NOP;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (w_flush) begin
                        o_cmd   = i_stat.none_dirty ? lsct_pkg::DP_FL_DONE
                                                    : lsct_pkg::DP_LOAD;
                        n_state = i_stat.none_dirty ? S_IDLE : S_FL_CHK;
                    end else if (i_op != lsct_pkg::OP_NONE) begin
                        o_cmd   = lsct_pkg::DP_LOAD;
                        n_state = S_BEGIN;
                    end
                end
            end
            S_BEGIN:   n_state = i_stat.used_zero ? S_INSTALL : S_ORD;
            S_ORD: begin
                o_cmd   = lsct_pkg::DP_RD_ORD;
                n_state = S_SEC;
            end
            S_SEC: begin
                o_cmd   = lsct_pkg::DP_RD_SEC;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd = lsct_pkg::DP_CMP;
                priority if (i_stat.match) n_state = i_stat.touch ? S_SH_CHK : S_EMIT;
                else if (!i_stat.scan_end) n_state = S_ORD;
                else if (i_stat.full)      n_state = S_EVICT;
                else                       n_state = S_INSTALL;
            end
            S_INSTALL: begin
                o_cmd   = lsct_pkg::DP_INSTALL;
                n_state = S_EMIT;
            end
            S_EVICT: begin
                o_cmd   = lsct_pkg::DP_EVICT;
                n_state = S_SH_CHK;
            end
            S_SH_CHK:  n_state = i_stat.scan_end ? S_MRU : S_SH_RD;
            S_SH_RD: begin
                o_cmd   = lsct_pkg::DP_SH_RD;
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd   = lsct_pkg::DP_SH_WR;
                n_state = S_SH_CHK;
            end
            S_MRU: begin
                o_cmd   = lsct_pkg::DP_MRU_WR;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd   = lsct_pkg::DP_EMIT;
                n_state = i_stat.more ? S_NEXT : S_IDLE;
            end
            S_NEXT: begin
                o_cmd   = lsct_pkg::DP_LOAD_NEXT;
                n_state = S_BEGIN;
            end
            // Flush walk over the dirty marks
            S_FL_CHK: begin
                o_cmd   = i_stat.dirty_i ? lsct_pkg::DP_NOP : lsct_pkg::DP_INC;
                n_state = i_stat.dirty_i ? S_FL_RD : S_FL_CHK;
            end
            S_FL_RD: begin
                o_cmd   = lsct_pkg::DP_FL_RD;
                n_state = S_FL_EMIT;
            end
            S_FL_EMIT: begin
                o_cmd   = lsct_pkg::DP_FL_EMIT;
                n_state = i_stat.fl_last ? S_IDLE : S_FL_CHK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

### design/lru_sector_cache_tags.sv
// ----------------------------------------------------------------------------
// lru_sector_cache_tags
// Tag, dirty and LRU controller of a fully associative disk-sector cache.
// ----------------------------------------------------------------------------
// A word is taken when i_start is high and o_busy is low; o_busy is then high
// from the next cycle and goes low in the cycle in which its last result is
// shown (an empty flush and the unused code never raise it). Each result appears
// for one cycle with o_strobe and cannot be held off. An access reads the LRU
// order entry, then the tag, then compares, for each slot in the lookup scan
// (tag and LRU order memories are read one entry a step), then shifts each LRU
// position after the slot when it moves to the MRU end; a prefetch repeats the
// lookup. A flush steps past each clean slot and reads and emits each dirty slot
// up to the last dirty one; a flush with nothing dirty answers at once.
`default_nettype none

module lru_sector_cache_tags #(
    parameter int unsigned NUM_SLOTS = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire lsct_pkg::t_in  i_item,
    output logic                o_busy,
    output logic                o_strobe,
    output lsct_pkg::t_out      o_result
);

`include "lru_sector_cache_tags_assert.svh"

    lsct_pkg::t_dp_op   w_cmd;
    lsct_pkg::t_dp_stat w_stat;
    logic               w_acc_res;
    logic               w_acc_start;

    lsct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_op    (i_item.operation),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    lsct_dpath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .o_stat   (w_stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Checks
    assign w_acc_res   = o_strobe && (o_result.kind == lsct_pkg::K_ACCESS ||
                                      o_result.kind == lsct_pkg::K_PREF);
    assign w_acc_start = i_start && !o_busy && (i_item.operation == lsct_pkg::OP_READ ||
                                                i_item.operation == lsct_pkg::OP_WRITE);

    `LSCT_ASSERT_NOW(a_res_busy, w_acc_res, $past(o_busy), "access result without work")
    `LSCT_ASSERT_NEXT(a_acc_busy, w_acc_start, o_busy, "access not started")
    `LSCT_ASSERT_NOW(a_idle_last, o_strobe && !o_busy, o_result.last, "idle after a non-last result")

endmodule

`default_nettype wire
